@@ sv/assert_macros.svh @@
// Assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

@@ sv/upn_pkg.sv @@
`default_nettype none
package upn_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_UTF8    = 3'd2,
    ST_ROOTED  = 3'd3,
    ST_DOTDOT  = 3'd4,
    ST_EMPTY   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    U8_ACCEPT = 3'd0,
    U8_TAIL1  = 3'd1,
    U8_E0     = 3'd2,
    U8_ED     = 3'd3,
    U8_TAIL2  = 3'd4,
    U8_F0     = 3'd5,
    U8_F4     = 3'd6,
    U8_TAIL3  = 3'd7
  } u8_phase_e;

  typedef enum logic [1:0] {
    SEG_EMPTY  = 2'd0,
    SEG_DOT    = 2'd1,
    SEG_DOTDOT = 2'd2,
    SEG_NORMAL = 2'd3
  } seg_e;

  // one request from front to back: expands to slash, dots, byte, status
  typedef struct packed {
    logic [7:0] ch;
    logic       pre_slash;
    logic [1:0] ndots;
    logic       has_ch;
    logic       done;
    status_e    status;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/upn_front.sv @@
`default_nettype none
module upn_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  input  wire logic        full_i,
  output logic             ready_o,
  output logic             push_o,
  output upn_pkg::cmd_t    cmd_o
);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  upn_pkg::u8_phase_e phase_q, phase_d;
  logic [1:0]         pos_q, pos_d;
  logic               letter_q, letter_d;
  upn_pkg::seg_e      seg_q, seg_d;
  logic               wrote_q, wrote_d;
  logic [3:0]         flags_q, flags_d;

  logic [7:0] b;
  logic [7:0] lo, hi;
  logic       accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign b       = (byte_i == CH_BSLASH) ? CH_SLASH : byte_i;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    letter_d = letter_q;
    seg_d    = seg_q;
    wrote_d  = wrote_q;
    flags_d  = flags_q;
    lo       = 8'h80;
    hi       = 8'hBF;
    cmd_o    = '0;
    cmd_o.status = upn_pkg::ST_OK;

    if (b == 8'h00) flags_d[0] = 1'b1;

    // strict UTF-8 decoder
    if (phase_q == upn_pkg::U8_ACCEPT) begin
      if (b[7]) begin
        if (b >= 8'hC2 && b <= 8'hDF) phase_d = upn_pkg::U8_TAIL1;
        else if (b == 8'hE0) phase_d = upn_pkg::U8_E0;
        else if (b == 8'hED) phase_d = upn_pkg::U8_ED;
        else if (b >= 8'hE1 && b <= 8'hEF) phase_d = upn_pkg::U8_TAIL2;
        else if (b == 8'hF0) phase_d = upn_pkg::U8_F0;
        else if (b == 8'hF4) phase_d = upn_pkg::U8_F4;
        else if (b >= 8'hF1 && b <= 8'hF3) phase_d = upn_pkg::U8_TAIL3;
        else flags_d[1] = 1'b1;
      end
    end else begin
      case (phase_q)
        upn_pkg::U8_E0: lo = 8'hA0;
        upn_pkg::U8_ED: hi = 8'h9F;
        upn_pkg::U8_F0: lo = 8'h90;
        upn_pkg::U8_F4: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        flags_d[1] = 1'b1;
        phase_d    = upn_pkg::U8_ACCEPT;
      end else begin
        case (phase_q)
          upn_pkg::U8_TAIL1: phase_d = upn_pkg::U8_ACCEPT;
          upn_pkg::U8_E0,
          upn_pkg::U8_ED,
          upn_pkg::U8_TAIL2: phase_d = upn_pkg::U8_TAIL1;
          default:           phase_d = upn_pkg::U8_TAIL2;
        endcase
      end
    end

    // rooted: leading slash or drive letter
    if (pos_q == 2'd0) begin
      if (b == CH_SLASH) flags_d[2] = 1'b1;
      letter_d = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
      pos_d    = 2'd1;
    end else if (pos_q == 2'd1) begin
      if (letter_q && b == CH_COLON) flags_d[2] = 1'b1;
      pos_d = 2'd2;
    end

    // segment handling
    if (b == CH_SLASH) begin
      if (seg_q == upn_pkg::SEG_DOTDOT) flags_d[3] = 1'b1;
      seg_d = upn_pkg::SEG_EMPTY;
    end else if (seg_q == upn_pkg::SEG_NORMAL) begin
      cmd_o.has_ch = 1'b1;
      cmd_o.ch     = b;
    end else if (b == CH_DOT && seg_q != upn_pkg::SEG_DOTDOT) begin
      seg_d = (seg_q == upn_pkg::SEG_EMPTY) ? upn_pkg::SEG_DOT : upn_pkg::SEG_DOTDOT;
    end else begin
      cmd_o.pre_slash = wrote_q;
      cmd_o.ndots     = 2'(seg_q);
      cmd_o.has_ch    = 1'b1;
      cmd_o.ch        = b;
      seg_d           = upn_pkg::SEG_NORMAL;
      wrote_d         = 1'b1;
    end

    if (last_i) begin
      if (seg_d == upn_pkg::SEG_DOTDOT) flags_d[3] = 1'b1;
      if (phase_d != upn_pkg::U8_ACCEPT) flags_d[1] = 1'b1;
      cmd_o.done = 1'b1;
      if (flags_d[0]) cmd_o.status = upn_pkg::ST_NULL;
      else if (flags_d[1]) cmd_o.status = upn_pkg::ST_UTF8;
      else if (flags_d[2]) cmd_o.status = upn_pkg::ST_ROOTED;
      else if (flags_d[3]) cmd_o.status = upn_pkg::ST_DOTDOT;
      else if (!wrote_d) cmd_o.status = upn_pkg::ST_EMPTY;
      else cmd_o.status = upn_pkg::ST_OK;
      phase_d  = upn_pkg::U8_ACCEPT;
      pos_d    = 2'd0;
      letter_d = 1'b0;
      seg_d    = upn_pkg::SEG_EMPTY;
      wrote_d  = 1'b0;
      flags_d  = '0;
    end
  end

  assign push_o = accept && (cmd_o.pre_slash || cmd_o.has_ch || cmd_o.done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= upn_pkg::U8_ACCEPT;
      pos_q    <= 2'd0;
      letter_q <= 1'b0;
      seg_q    <= upn_pkg::SEG_EMPTY;
      wrote_q  <= 1'b0;
      flags_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      letter_q <= letter_d;
      seg_q    <= seg_d;
      wrote_q  <= wrote_d;
      flags_q  <= flags_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/upn_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"
module upn_fifo #(
  parameter int unsigned Depth = upn_pkg::FIFO_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  upn_pkg::cmd_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output upn_pkg::cmd_t      data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  upn_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ASSERT_PROP(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Depth), "queue count overflow")

endmodule
`default_nettype wire

@@ sv/upn_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module upn_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  upn_pkg::cmd_t    head_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [7:0]       out_byte_o,
  output logic             has_byte_o,
  output logic             path_done_o,
  output upn_pkg::status_e status_o,
  output logic             run_last_o
);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT = 8'h2E;

  logic [2:0] idx_q, idx_d;
  logic [2:0] s1, s2, s3, total;
  logic       can_load, fire, is_last;

  logic             valid_q;
  logic [7:0]       byte_q, byte_d;
  logic             has_q, has_d;
  logic             done_q, done_d;
  upn_pkg::status_e st_q, st_d;
  logic             last_q;

  assign s1    = {2'b00, head_i.pre_slash};
  assign s2    = s1 + {1'b0, head_i.ndots};
  assign s3    = s2 + {2'b00, head_i.has_ch};
  assign total = s3 + {2'b00, head_i.done};

  assign can_load = !valid_q || ready_i;
  assign fire     = !empty_i && can_load;
  assign is_last  = (idx_q == total - 3'd1);
  assign pop_o    = fire && is_last;

  always_comb begin
    byte_d = 8'h00;
    has_d  = 1'b0;
    done_d = 1'b0;
    st_d   = upn_pkg::ST_OK;
    if (idx_q < s1) begin
      byte_d = CH_SLASH;
      has_d  = 1'b1;
    end else if (idx_q < s2) begin
      byte_d = CH_DOT;
      has_d  = 1'b1;
    end else if (idx_q < s3) begin
      byte_d = head_i.ch;
      has_d  = 1'b1;
    end else begin
      done_d = 1'b1;
      st_d   = head_i.status;
    end
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (fire) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      has_q  <= has_d;
      done_q <= done_d;
      st_q   <= st_d;
      last_q <= is_last;
    end
  end

  assign valid_o     = valid_q;
  assign out_byte_o  = byte_q;
  assign has_byte_o  = has_q;
  assign path_done_o = done_q;
  assign status_o    = st_q;
  assign run_last_o  = last_q;

  `ASSERT_PROP(a_idx_range, clk_i, rst_ni, empty_i || (idx_q < total), "step past request")
  `ASSERT_PROP(a_done_last, clk_i, rst_ni, !(valid_q && done_q) || last_q, "status not last")
  `ASSERT_NEVER(a_byte_done, clk_i, rst_ni, valid_q && has_q && done_q, "byte and status mixed")

endmodule
`default_nettype wire

@@ sv/utf8_path_normalizer_unit.sv @@
// Path: an accepted byte's request is written to the request queue, and its results are then registered at the output.
// Throughput: one input byte per cycle unless the request queue is full; a byte that yields k results
// sends them out one at a time, and bursts (up to five results) are absorbed by the request queue.
// Input stalls only when the request queue (FifoDepth entries) is full.
// Reset: asynchronous active-low rst_ni clears decoder, path state, queue and output valid.
`default_nettype none
module utf8_path_normalizer_unit #(
  parameter int unsigned FifoDepth = upn_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] path_byte
  input  wire logic        s_axis_tlast,   // path_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
  output logic [1:0]       m_axis_tuser,   // [0] has_byte, [1] path_done
  output logic             m_axis_tlast    // run_last
);

  upn_pkg::cmd_t    push_cmd, head_cmd;
  logic             push, pop, full, empty;
  logic [7:0]       out_byte;
  logic             has_byte, path_done, run_last;
  upn_pkg::status_e status;

  upn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  upn_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty)
  );

  upn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .out_byte_o  (out_byte),
    .has_byte_o  (has_byte),
    .path_done_o (path_done),
    .status_o    (status),
    .run_last_o  (run_last)
  );

  assign m_axis_tdata = {5'b00000, 3'(status), out_byte};
  assign m_axis_tuser = {path_done, has_byte};
  assign m_axis_tlast = run_last;

endmodule
`default_nettype wire

@@ tb/utf8_path_normalizer_unit_checker.sv @@
`timescale 1ns / 1ps
module utf8_path_normalizer_unit_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int unsigned      fail_count_o,
  output int unsigned      outstanding_o
);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  localparam logic [3:0] ERR_NUL    = 4'b0001;
  localparam logic [3:0] ERR_UTF8   = 4'b0010;
  localparam logic [3:0] ERR_ROOT   = 4'b0100;
  localparam logic [3:0] ERR_DOTDOT = 4'b1000;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_byte;
    logic             path_done;
    upn_pkg::status_e status;
    logic             run_last;
  } norm_item_t;

  norm_item_t norm_out_q[$];
  norm_item_t want;
  int unsigned misses = 0;

  upn_pkg::u8_phase_e dec_phase = upn_pkg::U8_ACCEPT;
  logic [1:0]         pos_cnt = 2'd0;
  logic               lead_alpha = 1'b0;
  upn_pkg::seg_e      seg = upn_pkg::SEG_EMPTY;
  logic               any_out = 1'b0;
  logic [3:0]         err_bits = 4'b0000;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp_val);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_val);
    misses++;
  endtask

  task automatic queue_result(input logic [7:0] ob, input logic has, input logic done,
                              input upn_pkg::status_e st);
    norm_item_t it;
    it.out_byte  = ob;
    it.has_byte  = has;
    it.path_done = done;
    it.status    = st;
    it.run_last  = 1'b0;
    norm_out_q.insert(norm_out_q.size(), it);
  endtask

  task automatic normalize_byte(input logic [7:0] raw, input logic fin);
    logic [7:0]       b;
    logic [7:0]       lo;
    logic [7:0]       hi;
    upn_pkg::status_e st;
    int unsigned      first_new;
    int               k;
    norm_item_t       tail;
    first_new = norm_out_q.size();
    b = (raw == CH_BSLASH) ? CH_SLASH : raw;
    if (b == 8'h00) err_bits |= ERR_NUL;

    if (dec_phase == upn_pkg::U8_ACCEPT) begin
      if (b >= 8'hC2 && b <= 8'hDF) dec_phase = upn_pkg::U8_TAIL1;
      else if (b == 8'hE0) dec_phase = upn_pkg::U8_E0;
      else if (b == 8'hED) dec_phase = upn_pkg::U8_ED;
      else if (b >= 8'hE1 && b <= 8'hEF) dec_phase = upn_pkg::U8_TAIL2;
      else if (b == 8'hF0) dec_phase = upn_pkg::U8_F0;
      else if (b == 8'hF4) dec_phase = upn_pkg::U8_F4;
      else if (b >= 8'hF1 && b <= 8'hF3) dec_phase = upn_pkg::U8_TAIL3;
      else if (b >= 8'h80) err_bits |= ERR_UTF8;
    end else begin
      lo = 8'h80;
      hi = 8'hBF;
      case (dec_phase)
        upn_pkg::U8_E0: lo = 8'hA0;
        upn_pkg::U8_ED: hi = 8'h9F;
        upn_pkg::U8_F0: lo = 8'h90;
        upn_pkg::U8_F4: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        err_bits |= ERR_UTF8;
        dec_phase = upn_pkg::U8_ACCEPT;
      end else if (dec_phase == upn_pkg::U8_TAIL1) begin
        dec_phase = upn_pkg::U8_ACCEPT;
      end else if (dec_phase inside {upn_pkg::U8_E0, upn_pkg::U8_ED, upn_pkg::U8_TAIL2}) begin
        dec_phase = upn_pkg::U8_TAIL1;
      end else begin
        dec_phase = upn_pkg::U8_TAIL2;
      end
    end

    if (pos_cnt == 2'd0) begin
      if (b == CH_SLASH) err_bits |= ERR_ROOT;
      lead_alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
      pos_cnt = 2'd1;
    end else if (pos_cnt == 2'd1) begin
      if (lead_alpha && b == CH_COLON) err_bits |= ERR_ROOT;
      pos_cnt = 2'd2;
    end

    if (b == CH_SLASH) begin
      if (seg == upn_pkg::SEG_DOTDOT) err_bits |= ERR_DOTDOT;
      seg = upn_pkg::SEG_EMPTY;
    end else if (seg == upn_pkg::SEG_NORMAL) begin
      queue_result(b, 1'b1, 1'b0, upn_pkg::ST_OK);
    end else if (b == CH_DOT && seg != upn_pkg::SEG_DOTDOT) begin
      seg = upn_pkg::seg_e'(seg + 2'd1);
    end else begin
      // held-back dots turn out to be part of an ordinary name
      if (any_out) queue_result(CH_SLASH, 1'b1, 1'b0, upn_pkg::ST_OK);
      for (k = 0; k < int'(seg); k++) queue_result(CH_DOT, 1'b1, 1'b0, upn_pkg::ST_OK);
      queue_result(b, 1'b1, 1'b0, upn_pkg::ST_OK);
      seg = upn_pkg::SEG_NORMAL;
      any_out = 1'b1;
    end

    if (fin) begin
      if (seg == upn_pkg::SEG_DOTDOT) err_bits |= ERR_DOTDOT;
      if (dec_phase != upn_pkg::U8_ACCEPT) err_bits |= ERR_UTF8;
      if ((err_bits & ERR_NUL) != 0) st = upn_pkg::ST_NULL;
      else if ((err_bits & ERR_UTF8) != 0) st = upn_pkg::ST_UTF8;
      else if ((err_bits & ERR_ROOT) != 0) st = upn_pkg::ST_ROOTED;
      else if ((err_bits & ERR_DOTDOT) != 0) st = upn_pkg::ST_DOTDOT;
      else if (!any_out) st = upn_pkg::ST_EMPTY;
      else st = upn_pkg::ST_OK;
      queue_result(8'h00, 1'b0, 1'b1, st);
      dec_phase = upn_pkg::U8_ACCEPT;
      pos_cnt = 2'd0;
      lead_alpha = 1'b0;
      seg = upn_pkg::SEG_EMPTY;
      any_out = 1'b0;
      err_bits = 4'b0000;
    end

    if (norm_out_q.size() > first_new) begin
      tail = norm_out_q.pop_back();
      tail.run_last = 1'b1;
      norm_out_q.insert(norm_out_q.size(), tail);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) normalize_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (norm_out_q.size() == 0) begin
          report("result with no request pending", m_axis_tdata, 16'h0000);
        end else begin
          want = norm_out_q.pop_front();
          if (m_axis_tdata[7:0] !== want.out_byte)
            report("out_byte", 16'(m_axis_tdata[7:0]), 16'(want.out_byte));
          if (m_axis_tdata[10:8] !== want.status)
            report("status", 16'(m_axis_tdata[10:8]), 16'(want.status));
          if (m_axis_tdata[15:11] !== 5'd0)
            report("tdata pad bits", 16'(m_axis_tdata[15:11]), 16'h0000);
          if (m_axis_tuser[0] !== want.has_byte)
            report("has_byte", 16'(m_axis_tuser[0]), 16'(want.has_byte));
          if (m_axis_tuser[1] !== want.path_done)
            report("path_done", 16'(m_axis_tuser[1]), 16'(want.path_done));
          if (m_axis_tlast !== want.run_last)
            report("run_last", 16'(m_axis_tlast), 16'(want.run_last));
        end
      end
    end
    fail_count_o <= misses;
    outstanding_o <= norm_out_q.size();
  end

endmodule

@@ tb/utf8_path_normalizer_unit_test.sv @@
`timescale 1ns / 1ps
module utf8_path_normalizer_unit_test;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam int unsigned ITEM_TARGET = 450;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;
  wire         m_axis_tlast;
  int unsigned fail_count_o;
  int unsigned outstanding_o;

  logic [7:0]  path_q[$];
  int unsigned sent = 0;
  logic        calm = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  utf8_path_normalizer_unit dut (.*);

  utf8_path_normalizer_unit_checker chk (.*);

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] rnd(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic add_byte(input logic [7:0] b);
    path_q.insert(path_q.size(), b);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_path();
    foreach (path_q[i]) put_byte(path_q[i], i == path_q.size() - 1);
    path_q.delete();
  endtask

  task automatic add_utf8(input logic allow_bad);
    logic [7:0] lead;
    case ($urandom_range(allow_bad ? 3 : 2, 0))
      0: begin
        add_byte(rnd(8'hC2, 8'hDF));
        add_byte(rnd(8'h80, 8'hBF));
      end
      1: begin
        case ($urandom_range(3, 0))
          0: lead = 8'hE0;
          1: lead = 8'hED;
          default: lead = rnd(8'hE1, 8'hEF);
        endcase
        add_byte(lead);
        if (lead == 8'hE0) add_byte(rnd(8'hA0, 8'hBF));
        else if (lead == 8'hED) add_byte(rnd(8'h80, 8'h9F));
        else add_byte(rnd(8'h80, 8'hBF));
        add_byte(rnd(8'h80, 8'hBF));
      end
      2: begin
        case ($urandom_range(3, 0))
          0: lead = 8'hF0;
          1: lead = 8'hF4;
          default: lead = rnd(8'hF1, 8'hF3);
        endcase
        add_byte(lead);
        if (lead == 8'hF0) add_byte(rnd(8'h90, 8'hBF));
        else if (lead == 8'hF4) add_byte(rnd(8'h80, 8'h8F));
        else add_byte(rnd(8'h80, 8'hBF));
        add_byte(rnd(8'h80, 8'hBF));
        add_byte(rnd(8'h80, 8'hBF));
      end
      default: begin
        case ($urandom_range(3, 0))
          0: begin
            add_byte(rnd(8'hC0, 8'hC1));
            add_byte(rnd(8'h80, 8'hBF));
          end
          1: add_byte(rnd(8'hF5, 8'hFF));
          2: add_byte(rnd(8'h80, 8'hBF));
          default: add_byte(rnd(8'hE0, 8'hF4));
        endcase
      end
    endcase
  endtask

  // mostly well-formed names and separators; a few paths carry raw noise
  task automatic build_path();
    int unsigned roll;
    logic        messy;
    messy = ($urandom_range(7, 0) == 0);
    repeat ($urandom_range(6, 1)) begin
      roll = $urandom_range(99, 0);
      if (messy && roll < 30) begin
        add_byte(rnd(0, 255));
      end else if (roll < 35) begin
        repeat ($urandom_range(4, 1)) add_byte(rnd(8'h21, 8'h7E));
      end else if (roll < 50) begin
        add_byte(CH_DOT);
      end else if (roll < 62) begin
        add_byte($urandom_range(1, 0) ? CH_SLASH : CH_BSLASH);
      end else if (roll < 70) begin
        add_byte(CH_DOT);
        add_byte(CH_DOT);
        add_byte($urandom_range(1, 0) ? CH_SLASH : CH_BSLASH);
      end else if (roll < 75) begin
        add_byte($urandom_range(1, 0) ? rnd(8'h41, 8'h5A) : rnd(8'h61, 8'h7A));
        add_byte(CH_COLON);
      end else begin
        add_utf8(messy);
      end
    end
  endtask

  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(24, 1)) @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("utf8_path_normalizer_unit_test: errors");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    path_q = {CH_DOT};
    send_path();
    path_q = {CH_BSLASH, 8'h78};
    send_path();
    path_q = {8'h43, CH_COLON};
    send_path();
    path_q = {CH_DOT, CH_DOT};
    send_path();
    path_q = {8'h61, 8'h00};
    send_path();
    path_q = {8'hED, 8'hA0, 8'h80};
    send_path();
    path_q = {8'hF4, 8'h90};
    send_path();
    path_q = {8'hC0, 8'hAF};
    send_path();
    path_q = {8'hE2, 8'h82};
    send_path();
    path_q = {8'hFF};
    send_path();
    // held dots released together with slash and status: longest burst
    path_q = {8'h78, CH_SLASH, CH_DOT, CH_DOT, 8'h62};
    send_path();

    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(3, 0) == 0);
      build_path();
      send_path();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding_o != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count_o == 0) begin
      $display("utf8_path_normalizer_unit_test: clean");
    end else begin
      $display("utf8_path_normalizer_unit_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/upn_pkg.sv
sv/upn_front.sv
sv/upn_fifo.sv
sv/upn_back.sv
sv/utf8_path_normalizer_unit.sv
tb/utf8_path_normalizer_unit_checker.sv
tb/utf8_path_normalizer_unit_test.sv
